// File: rtl/apt_pkg.sv
// Shared types, constants and helpers for the alarm pulse trigger rotator.
package apt_pkg;

    // Field widths
    localparam int unsigned NowW    = 32;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinW    = 6;
    localparam int unsigned SecW    = 6;
    localparam int unsigned WdayW   = 3;
    localparam int unsigned MaskW   = 7;
    localparam int unsigned PulseW  = 16;
    localparam int unsigned RelayW  = 3;
    localparam int unsigned EventW  = 2;
    localparam int unsigned SlotW   = 2;

    // Stream widths
    localparam int unsigned InDataW  = 56;
    localparam int unsigned InUserW  = 1;
    localparam int unsigned OutDataW = 8;
    localparam int unsigned OutUserW = EventW;

    // Configuration port
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_HOUR   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MINUTE = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MASK   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_PULSE  = 3'd4;

    // Register reset values
    localparam logic [HourW-1:0]  RST_HOUR   = 5'd7;
    localparam logic [MinW-1:0]   RST_MINUTE = 6'd0;
    localparam logic [MaskW-1:0]  RST_MASK   = 7'd0;
    localparam logic [PulseW-1:0] RST_PULSE  = 16'd1000;

    // Skip hold-off window in ms
    localparam logic [NowW-1:0] SKIP_GAP_MS = 32'd5000;

    // Relay slot codes, NONE means no relay is driven
    localparam logic [SlotW-1:0] SLOT_NONE = 2'd0;
    localparam logic [SlotW-1:0] SLOT_1    = 2'd1;
    localparam logic [SlotW-1:0] SLOT_2    = 2'd2;
    localparam logic [SlotW-1:0] SLOT_3    = 2'd3;

    // Event codes
    localparam logic [EventW-1:0] EV_NONE    = 2'd0;
    localparam logic [EventW-1:0] EV_SKIPPED = 2'd1;
    localparam logic [EventW-1:0] EV_STARTED = 2'd2;
    localparam logic [EventW-1:0] EV_ENDED   = 2'd3;

    typedef struct packed {
        logic              enable;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
        logic [MaskW-1:0]  mask;
        logic [PulseW-1:0] pulse_ms;
    } cfg_t;

    typedef struct packed {
        logic [NowW-1:0]  now_ms;
        logic [HourW-1:0] clock_hour;
        logic [MinW-1:0]  clock_minute;
        logic [SecW-1:0]  clock_second;
        logic [WdayW-1:0] clock_weekday;
        logic             time_valid;
        logic             skip_request;
    } poll_t;

    typedef struct packed {
        logic [RelayW-1:0] relay_drive;
        logic [EventW-1:0] event_code;
    } res_t;

    // Map the clock weekday (0 Sunday) onto the mask bit (0 Monday)
    function automatic logic [WdayW-1:0] day_bit(input logic [WdayW-1:0] wday);
        logic [WdayW-1:0] b;
        case (wday)
            3'd0:    b = 3'd6;
            3'd1:    b = 3'd0;
            3'd2:    b = 3'd1;
            3'd3:    b = 3'd2;
            3'd4:    b = 3'd3;
            3'd5:    b = 3'd4;
            3'd6:    b = 3'd5;
            default: b = 3'd6;
        endcase
        return b;
    endfunction

    // One-hot relay pattern for a slot
    function automatic logic [RelayW-1:0] slot_onehot(input logic [SlotW-1:0] slot);
        logic [RelayW-1:0] r;
        case (slot)
            SLOT_1:  r = 3'b001;
            SLOT_2:  r = 3'b010;
            SLOT_3:  r = 3'b100;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

    // Next slot in the rotation 1, 2, 3, 1
    function automatic logic [SlotW-1:0] slot_advance(input logic [SlotW-1:0] slot);
        logic [SlotW-1:0] n;
        case (slot)
            SLOT_1:  n = SLOT_2;
            SLOT_2:  n = SLOT_3;
            default: n = SLOT_1;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/apt_cfg_regs.sv
// Configuration register file for the alarm schedule and pulse length.
module apt_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [apt_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [apt_pkg::CfgDataW-1:0] cfg_data,
    output apt_pkg::cfg_t               cfg
);
    import apt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed field, drop unknown indexes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ENABLE: cfg_next.enable   = cfg_data[0];
                CFG_HOUR:   cfg_next.hour     = cfg_data[HourW-1:0];
                CFG_MINUTE: cfg_next.minute   = cfg_data[MinW-1:0];
                CFG_MASK:   cfg_next.mask     = cfg_data[MaskW-1:0];
                CFG_PULSE:  cfg_next.pulse_ms = cfg_data[PulseW-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable   <= 1'b0;
            cfg_reg.hour     <= RST_HOUR;
            cfg_reg.minute   <= RST_MINUTE;
            cfg_reg.mask     <= RST_MASK;
            cfg_reg.pulse_ms <= RST_PULSE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/apt_core.sv
// Alarm match, skip bookkeeping, pulse timing and relay rotation state.
module apt_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  apt_pkg::cfg_t cfg,
    input  apt_pkg::poll_t poll,
    output apt_pkg::res_t res
);
    import apt_pkg::*;

    logic             pulse_active_reg, pulse_active_next;
    logic [NowW-1:0]  stop_time_reg, stop_time_next;
    logic [SlotW-1:0] active_slot_reg, active_slot_next;
    logic [SlotW-1:0] upcoming_slot_reg, upcoming_slot_next;
    logic             skip_pending_reg, skip_pending_next;
    logic [NowW-1:0]  last_skip_reg, last_skip_next;

    logic             skip_now;
    logic             time_ok;
    logic             day_ok;
    logic             match;
    logic [NowW-1:0]  gap;
    logic [EventW-1:0] event_code;

    // Match the poll against the schedule
    always_comb begin
        time_ok = (poll.clock_hour == cfg.hour) && (poll.clock_minute == cfg.minute)
                  && (poll.clock_second == '0);
        day_ok  = cfg.mask[day_bit(poll.clock_weekday)];
        match   = poll.time_valid && time_ok && day_ok;
        gap     = poll.now_ms - last_skip_reg;
    end

    // Next state for one poll
    always_comb begin
        skip_now           = skip_pending_reg | poll.skip_request;
        pulse_active_next  = pulse_active_reg;
        stop_time_next     = stop_time_reg;
        active_slot_next   = active_slot_reg;
        upcoming_slot_next = upcoming_slot_reg;
        skip_pending_next  = skip_now;
        last_skip_next     = last_skip_reg;
        event_code         = EV_NONE;
        if (pulse_active_reg) begin
            // End the pulse once the count passes the stop time
            if (poll.now_ms > stop_time_reg) begin
                pulse_active_next = 1'b0;
                stop_time_next    = '0;
                active_slot_next  = SLOT_NONE;
                event_code        = EV_ENDED;
            end
        end else if (cfg.enable && match) begin
            if (skip_now) begin
                // Consume the pending skip
                skip_pending_next = 1'b0;
                last_skip_next    = poll.now_ms;
                event_code        = EV_SKIPPED;
            end else if (gap > SKIP_GAP_MS) begin
                // Start a pulse on the next relay
                pulse_active_next  = 1'b1;
                stop_time_next     = poll.now_ms + {{(NowW-PulseW){1'b0}}, cfg.pulse_ms};
                active_slot_next   = upcoming_slot_reg;
                upcoming_slot_next = slot_advance(upcoming_slot_reg);
                event_code         = EV_STARTED;
            end
        end
        res.relay_drive = pulse_active_next ? slot_onehot(active_slot_next) : '0;
        res.event_code  = event_code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_active_reg  <= 1'b0;
            stop_time_reg     <= '0;
            active_slot_reg   <= SLOT_NONE;
            upcoming_slot_reg <= SLOT_1;
            skip_pending_reg  <= 1'b0;
            last_skip_reg     <= '0;
        end else if (step) begin
            pulse_active_reg  <= pulse_active_next;
            stop_time_reg     <= stop_time_next;
            active_slot_reg   <= active_slot_next;
            upcoming_slot_reg <= upcoming_slot_next;
            skip_pending_reg  <= skip_pending_next;
            last_skip_reg     <= last_skip_next;
        end
    end

endmodule

// File: rtl/alarm_pulse_trigger_rotator_core.sv
// Pipeline: an accepted input transaction passes an input register, then a result
// register, to m_tvalid. Throughput: one poll per cycle while m_tready does not hold
// a pending result; both registers bracket the state update and advance together.
// Reset: aresetn is synchronous and active low; it empties both registers,
// restores configuration defaults and clears the pulse, skip and rotation state.
module alarm_pulse_trigger_rotator_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Poll input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // now_ms[31:0], clock_hour[36:32], clock_minute[42:37], clock_second[48:43],
    // clock_weekday[51:49], skip_request[52], zero[55:53]
    input  logic [apt_pkg::InDataW-1:0]   s_tdata,
    // time_valid[0]
    input  logic [apt_pkg::InUserW-1:0]   s_tuser,
    // Result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // relay_drive[2:0], zero[7:3]
    output logic [apt_pkg::OutDataW-1:0]  m_tdata,
    // event_code[1:0]
    output logic [apt_pkg::OutUserW-1:0]  m_tuser,
    // Configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [apt_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [apt_pkg::CfgDataW-1:0]  cfg_data
);
    import apt_pkg::*;

    logic  in_vld_reg, in_vld_next;
    poll_t in_reg;
    logic  out_vld_reg, out_vld_next;
    res_t  out_reg;
    res_t  res;
    cfg_t  cfg;
    logic  advance;
    logic  s_accept;
    logic  step;

    assign cfg_ready = 1'b1;

    apt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline control: both stages move when the result slot frees up
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign step     = in_vld_reg && advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = advance ? in_vld_reg : out_vld_reg;
    end

    apt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (cfg),
        .poll    (in_reg),
        .res     (res)
    );

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture the poll and the result
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg.now_ms        <= s_tdata[31:0];
            in_reg.clock_hour    <= s_tdata[36:32];
            in_reg.clock_minute  <= s_tdata[42:37];
            in_reg.clock_second  <= s_tdata[48:43];
            in_reg.clock_weekday <= s_tdata[51:49];
            in_reg.skip_request  <= s_tdata[52];
            in_reg.time_valid    <= s_tuser[0];
        end
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OutDataW-RelayW){1'b0}}, out_reg.relay_drive};
    assign m_tuser  = out_reg.event_code;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the alarm pulse trigger rotator core.
`timescale 1ns / 1ps

module testbench;
    import apt_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned PHASES       = 10;
    localparam int unsigned PHASE_POLLS  = 55;

    // Index with no register behind it; a write there must change nothing
    localparam logic [CfgIdxW-1:0] CFG_SPARE = 3'd7;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata;
    logic [InUserW-1:0]   s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OutDataW-1:0]  m_tdata;
    logic [OutUserW-1:0]  m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    // Alarm schedule as the block should hold it
    cfg_t            alarm_cfg;
    // Pulse, skip and rotation state as the block should hold it
    logic            pulse_on;
    logic [NowW-1:0] stop_ms;
    logic [SlotW-1:0] live_slot;
    logic [SlotW-1:0] next_slot;
    logic            skip_armed;
    logic [NowW-1:0] skip_stamp;

    res_t            relay_events_due[$];
    int unsigned     miscompare_count;
    int unsigned     cycle_count;
    logic [NowW-1:0] tick_ms;
    logic            src_idle_on;
    logic            sink_idle_on;

    alarm_pulse_trigger_rotator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Advance the expected alarm state by one poll and return its result
    function automatic res_t step_alarm(input poll_t p);
        res_t        r;
        int unsigned day;
        logic        hit;
        r.event_code = EV_NONE;
        if (p.skip_request)
            skip_armed = 1'b1;
        if (pulse_on) begin
            if (p.now_ms > stop_ms) begin
                pulse_on   = 1'b0;
                stop_ms    = '0;
                live_slot  = SLOT_NONE;
                r.event_code = EV_ENDED;
            end
        end else if (alarm_cfg.enable) begin
            // clock counts from Sunday, the mask from Monday
            day = (int'(p.clock_weekday) + 6) % 7;
            hit = p.time_valid && p.clock_hour == alarm_cfg.hour
                  && p.clock_minute == alarm_cfg.minute && p.clock_second == '0
                  && alarm_cfg.mask[day];
            if (hit) begin
                if (skip_armed) begin
                    skip_armed   = 1'b0;
                    skip_stamp   = p.now_ms;
                    r.event_code = EV_SKIPPED;
                end else if (p.now_ms - skip_stamp > SKIP_GAP_MS) begin
                    pulse_on     = 1'b1;
                    stop_ms      = p.now_ms + NowW'(alarm_cfg.pulse_ms);
                    live_slot    = next_slot;
                    next_slot    = (next_slot == SLOT_3) ? SLOT_1 : next_slot + 1'b1;
                    r.event_code = EV_STARTED;
                end
            end
        end
        r.relay_drive = pulse_on ? RelayW'(1 << (live_slot - 1)) : '0;
        return r;
    endfunction

    function automatic poll_t poll_at(input logic [NowW-1:0] now, input logic [HourW-1:0] hr,
                                      input logic [MinW-1:0] mn, input logic [SecW-1:0] sc,
                                      input logic [WdayW-1:0] wd, input logic ok,
                                      input logic skip);
        poll_t p;
        p.now_ms        = now;
        p.clock_hour    = hr;
        p.clock_minute  = mn;
        p.clock_second  = sc;
        p.clock_weekday = wd;
        p.time_valid    = ok;
        p.skip_request  = skip;
        return p;
    endfunction

    // Half the polls hit the schedule exactly; the rest are arbitrary clock readings
    function automatic poll_t random_poll();
        poll_t       p;
        int unsigned b;
        if ($urandom_range(0, 29) == 0)
            tick_ms = $urandom;
        else
            tick_ms = tick_ms + $urandom_range(0, 2500);
        p.now_ms       = tick_ms;
        p.skip_request = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 1) == 0) begin
            p.clock_hour   = alarm_cfg.hour;
            p.clock_minute = alarm_cfg.minute;
            p.clock_second = '0;
            p.time_valid   = 1'b1;
            b = $urandom_range(0, 6);
            if (alarm_cfg.mask != '0) begin
                while (!alarm_cfg.mask[b])
                    b = $urandom_range(0, 6);
            end
            // Sunday may also show up as the out-of-range weekday 7
            if (b == 6)
                p.clock_weekday = $urandom_range(0, 1) ? 3'd7 : 3'd0;
            else
                p.clock_weekday = WdayW'(b + 1);
        end else begin
            p.clock_hour    = HourW'($urandom_range(0, 31));
            p.clock_minute  = MinW'($urandom_range(0, 63));
            p.clock_second  = SecW'($urandom_range(0, 63));
            p.clock_weekday = WdayW'($urandom_range(0, 7));
            p.time_valid    = ($urandom_range(0, 3) != 0);
        end
        return p;
    endfunction

    // Send one poll transaction and queue its expected result
    task automatic send_poll(input poll_t p);
        int unsigned gap;
        gap = src_idle_on ? $urandom_range(0, 10) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, p.skip_request, p.clock_weekday, p.clock_second,
                     p.clock_minute, p.clock_hour, p.now_ms};
        s_tuser  <= p.time_valid;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        relay_events_due.push_back(step_alarm(p));
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (relay_events_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_ENABLE: alarm_cfg.enable   = val[0];
            CFG_HOUR:   alarm_cfg.hour     = val[HourW-1:0];
            CFG_MINUTE: alarm_cfg.minute   = val[MinW-1:0];
            CFG_MASK:   alarm_cfg.mask     = val[MaskW-1:0];
            CFG_PULSE:  alarm_cfg.pulse_ms = val[PulseW-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold m_tready low for a random stall before each result while sink_idle_on is set
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = sink_idle_on ? $urandom_range(0, 10) : 0;
            @(negedge aclk);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : check_results
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.relay_drive = m_tdata[RelayW-1:0];
            got.event_code  = m_tuser;
            if (relay_events_due.size() == 0) begin
                miscompare_count++;
                if (miscompare_count <= REPORT_MAX)
                    $display("unexpected result: relay %b event %0d",
                             got.relay_drive, got.event_code);
            end else begin
                want = relay_events_due.pop_front();
                if (got.relay_drive !== want.relay_drive
                        || got.event_code !== want.event_code) begin
                    miscompare_count++;
                    if (miscompare_count <= REPORT_MAX)
                        $display("result mismatch: relay exp %b got %b, event exp %0d got %0d",
                                 want.relay_drive, got.relay_drive,
                                 want.event_code, got.event_code);
                end
            end
        end
    end

    // Schedule disabled at reset: nothing may happen, whatever the clock says
    task automatic test_idle_defaults;
        send_poll(poll_at('0, 5'd7, 6'd0, 6'd0, 3'd1, 1'b1, 1'b0));
        send_poll(poll_at('1, 5'd31, 6'd63, 6'd63, 3'd7, 1'b1, 1'b0));
    endtask

    // Hold-off after reset, zero-length pulse, skip while pulsing, hold-off after a skip
    task automatic test_skip_holdoff;
        drain();
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_HOUR, 16'd23);
        write_reg(CFG_MINUTE, 16'd59);
        write_reg(CFG_MASK, 16'h007F);
        write_reg(CFG_PULSE, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_poll(poll_at(32'd3000, 5'd23, 6'd59, 6'd0, 3'd3, 1'b1, 1'b0));
        send_poll(poll_at(32'd5000, 5'd23, 6'd59, 6'd0, 3'd3, 1'b1, 1'b0));
        send_poll(poll_at(32'd5001, 5'd23, 6'd59, 6'd0, 3'd3, 1'b1, 1'b0));
        send_poll(poll_at(32'd5001, 5'd23, 6'd59, 6'd0, 3'd3, 1'b1, 1'b1));
        send_poll(poll_at(32'd5002, 5'd23, 6'd59, 6'd0, 3'd3, 1'b1, 1'b0));
        send_poll(poll_at(32'd6000, 5'd23, 6'd59, 6'd0, 3'd3, 1'b1, 1'b0));
        send_poll(poll_at(32'd11000, 5'd23, 6'd59, 6'd0, 3'd3, 1'b1, 1'b0));
        send_poll(poll_at(32'd11001, 5'd23, 6'd59, 6'd0, 3'd3, 1'b1, 1'b0));
        send_poll(poll_at(32'd11002, 5'd23, 6'd59, 6'd1, 3'd3, 1'b1, 1'b0));
    endtask

    // Sunday-only mask: weekday 7 counts as Sunday, Monday does not match
    task automatic test_weekday_wrap;
        drain();
        write_reg(CFG_MASK, 16'h0040);
        send_poll(poll_at(32'd20000, 5'd23, 6'd59, 6'd0, 3'd7, 1'b1, 1'b0));
        send_poll(poll_at(32'd20001, 5'd23, 6'd59, 6'd0, 3'd7, 1'b1, 1'b0));
        send_poll(poll_at(32'd25000, 5'd23, 6'd59, 6'd0, 3'd1, 1'b1, 1'b0));
        send_poll(poll_at(32'd30000, 5'd23, 6'd59, 6'd0, 3'd0, 1'b1, 1'b0));
        send_poll(poll_at(32'd30001, 5'd23, 6'd59, 6'd0, 3'd0, 1'b1, 1'b0));
    endtask

    // Clock fields past their range, and an unknown time, never match
    task automatic test_clock_out_of_range;
        send_poll(poll_at(32'd40000, 5'd31, 6'd59, 6'd0, 3'd0, 1'b1, 1'b0));
        send_poll(poll_at(32'd40000, 5'd23, 6'd63, 6'd0, 3'd0, 1'b1, 1'b0));
        send_poll(poll_at(32'd40000, 5'd23, 6'd59, 6'd63, 3'd0, 1'b1, 1'b0));
        send_poll(poll_at(32'd40000, 5'd23, 6'd59, 6'd0, 3'd0, 1'b0, 1'b0));
    endtask

    // Longest pulse; a stop time that wraps past 2^32 ends on the next later count
    task automatic test_stop_wrap;
        drain();
        write_reg(CFG_HOUR, 16'd0);
        write_reg(CFG_MINUTE, 16'd0);
        write_reg(CFG_PULSE, 16'hFFFF);
        send_poll(poll_at(32'hFFFF_FFF0, 5'd0, 6'd0, 6'd0, 3'd0, 1'b1, 1'b0));
        send_poll(poll_at(32'hFFFF_FFFF, 5'd0, 6'd0, 6'd1, 3'd0, 1'b1, 1'b0));
        send_poll(poll_at(32'h0001_0000, 5'd0, 6'd0, 6'd0, 3'd0, 1'b1, 1'b0));
        send_poll(poll_at(32'h0001_FFFF, 5'd0, 6'd0, 6'd1, 3'd0, 1'b1, 1'b0));
        send_poll(poll_at(32'h0002_0000, 5'd0, 6'd0, 6'd1, 3'd0, 1'b1, 1'b0));
    endtask

    // Random polls under a new schedule each phase; extremes, off and empty mask first
    task automatic test_random_schedules;
        cfg_t next;
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            next.enable   = 1'b1;
            next.hour     = HourW'($urandom_range(0, 23));
            next.minute   = MinW'($urandom_range(0, 59));
            next.mask     = MaskW'($urandom_range(1, 127));
            next.pulse_ms = PulseW'($urandom_range(1, 3000));
            case (ph)
                0: begin
                    next.hour = 5'd0; next.minute = 6'd0;
                    next.mask = 7'h7F; next.pulse_ms = 16'd1;
                end
                1: begin
                    next.hour = 5'd23; next.minute = 6'd59;
                    next.mask = 7'h7F; next.pulse_ms = 16'hFFFF;
                end
                2: next.enable = 1'b0;
                3: next.mask = 7'h00;
                default: ;
            endcase
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            drain();
            write_reg(CFG_ENABLE, CfgDataW'(next.enable));
            write_reg(CFG_HOUR, CfgDataW'(next.hour));
            write_reg(CFG_MINUTE, CfgDataW'(next.minute));
            write_reg(CFG_MASK, CfgDataW'(next.mask));
            write_reg(CFG_PULSE, next.pulse_ms);
            for (int unsigned n = 0; n < PHASE_POLLS; n++)
                send_poll(random_poll());
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cycle_count  = 0;
        miscompare_count = 0;
        tick_ms      = 32'd40000;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        alarm_cfg.enable   = 1'b0;
        alarm_cfg.hour     = RST_HOUR;
        alarm_cfg.minute   = RST_MINUTE;
        alarm_cfg.mask     = RST_MASK;
        alarm_cfg.pulse_ms = RST_PULSE;
        pulse_on   = 1'b0;
        stop_ms    = '0;
        live_slot  = SLOT_NONE;
        next_slot  = SLOT_1;
        skip_armed = 1'b0;
        skip_stamp = '0;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_defaults();
        test_skip_holdoff();
        test_weekday_wrap();
        test_clock_out_of_range();
        test_stop_wrap();
        test_random_schedules();
        drain();

        if (miscompare_count == 0 && relay_events_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
